// ===== rtl/one_way_elevator_request_sort_top_assert.svh =====
// Assertion macros for the RTL of the elevator request queue.
`ifndef ONE_WAY_ELEVATOR_REQUEST_SORT_TOP_ASSERT_SVH
`define ONE_WAY_ELEVATOR_REQUEST_SORT_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define OWERS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define OWERS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/owers_pkg.sv =====
package owers_pkg;

  // Result status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // Operation codes on the mode field
  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_POP_RD,
    ST_POP_HEAD,
    ST_PL_RD,
    ST_PL_WR,
    ST_DONE
  } owers_state_e;

endpackage

// ===== rtl/owers_ram.sv =====
module owers_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one read port with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/one_way_elevator_request_sort_top.sv =====
// One-way elevator (C-LOOK) request queue.
// Input channel (in_valid_i/in_ready_o) carries mode_i, req_key_i and req_tag_i.
// Mode insert places the request in scan order: at or above the head key in the
// first ascending run, below it in the second run; equal keys go after their
// peers. Mode pop removes and returns the head. Every transfer in yields one
// result on the output channel (out_valid_o/out_ready_i): status, slot,
// head_key, head_tag and occupancy.
// Entries live in a single-port-write, registered-read RAM and are walked by a
// sequencer one entry at a time (read, then compare or move). An insert scans
// for its slot, shifts the later entries up and writes itself; a pop reads the
// head and shifts the rest down; a refused insert or an empty pop skips to the result.
// Reset empties the queue at once; RAM contents are not cleared.
// The result sits in an output register, so a new item is taken while it
// waits; if the receiver stalls with a second result ready, the sequencer holds
// that result and takes no further item until the register frees.
module one_way_elevator_request_sort_top #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [KEY_BITS-1:0]          req_key_i,
  input  logic [TAG_BITS-1:0]          req_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [$clog2(DEPTH+1)-1:0]   slot_o,
  output logic [KEY_BITS-1:0]          head_key_o,
  output logic [TAG_BITS-1:0]          head_tag_o,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy_o
);
  import owers_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + TAG_BITS;
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  owers_state_e state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d;
  logic [KEY_BITS-1:0] key_q, key_d, prev_q, prev_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                lo_q, lo_d, seen_q, seen_d;
  logic [1:0]          rstat_q, rstat_d;
  logic [CW-1:0]       rslot_q, rslot_d;
  logic [KEY_BITS-1:0] rhkey_q, rhkey_d;
  logic [TAG_BITS-1:0] rhtag_q, rhtag_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          status_q, status_d;
  logic [CW-1:0]       slot_q, slot_d, occ_q, occ_d;
  logic [KEY_BITS-1:0] hkey_q, hkey_d;
  logic [TAG_BITS-1:0] htag_q, htag_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [EW-1:0]       mem_wdata, mem_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;
  logic [CW-1:0]       idx_inc, idx_dec;
  logic                inv, seen_n, stop;
  logic [CW-1:0]       sh_pos;
  logic                sh_go;

  owers_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_key  = mem_rdata[EW-1:TAG_BITS];
  assign rd_tag  = mem_rdata[TAG_BITS-1:0];
  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);

  // Scan step: run break and stop test against the previous key
  assign inv    = rd_key < prev_q;
  assign seen_n = seen_q | inv;
  assign stop   = lo_q ? (seen_n && (key_q < rd_key)) : (inv || (key_q < rd_key));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    key_d       = key_q;
    tag_d       = tag_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    seen_d      = seen_q;
    rstat_d     = rstat_q;
    rslot_d     = rslot_q;
    rhkey_d     = rhkey_q;
    rhtag_d     = rhtag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    slot_d      = slot_q;
    occ_d       = occ_q;
    hkey_d      = hkey_q;
    htag_d      = htag_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = idx_q[AW-1:0];
    in_ready_o  = 1'b0;
    sh_pos      = cnt_q;
    sh_go       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d   = req_key_i;
          tag_d   = req_tag_i;
          rstat_d = StatusOk;
          rslot_d = '0;
          rhkey_d = '0;
          rhtag_d = '0;
          idx_d   = '0;
          if (mode_i == ModePop) begin
            if (cnt_q == '0) begin
              rstat_d = StatusEmpty;
              state_d = ST_DONE;
            end else begin
              state_d = ST_POP_RD;
            end
          end else if (cnt_q == CntFull) begin
            rstat_d = StatusFull;
            state_d = ST_DONE;
          end else if (cnt_q == '0) begin
            pos_d   = '0;
            state_d = ST_INS_WR;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (idx_q == '0) begin
          prev_d = rd_key;
          lo_d   = key_q < rd_key;
          seen_d = 1'b0;
          if (idx_inc < cnt_q) begin
            idx_d   = idx_inc;
            state_d = ST_SCAN_RD;
          end else begin
            sh_go = 1'b1;
          end
        end else if (stop) begin
          sh_pos = idx_q;
          sh_go  = 1'b1;
        end else begin
          prev_d = rd_key;
          seen_d = seen_n;
          if (idx_inc < cnt_q) begin
            idx_d   = idx_inc;
            state_d = ST_SCAN_RD;
          end else begin
            sh_go = 1'b1;
          end
        end
        if (sh_go) begin
          pos_d   = sh_pos;
          idx_d   = cnt_q;
          state_d = (cnt_q > sh_pos) ? ST_SH_RD : ST_INS_WR;
        end
      end
      ST_SH_RD: begin
        mem_raddr = idx_dec[AW-1:0];
        state_d   = ST_SH_WR;
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        idx_d     = idx_dec;
        state_d   = (idx_dec > pos_q) ? ST_SH_RD : ST_INS_WR;
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = {key_q, tag_q};
        cnt_d     = cnt_q + CW'(1);
        rslot_d   = pos_q;
        state_d   = ST_DONE;
      end
      ST_POP_RD: begin
        mem_raddr = '0;
        state_d   = ST_POP_HEAD;
      end
      ST_POP_HEAD: begin
        rhkey_d = rd_key;
        rhtag_d = rd_tag;
        if (cnt_q > CW'(1)) begin
          state_d = ST_PL_RD;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_PL_RD: begin
        mem_raddr = idx_inc[AW-1:0];
        state_d   = ST_PL_WR;
      end
      ST_PL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        idx_d     = idx_inc;
        if ((idx_q + CW'(2)) < cnt_q) begin
          state_d = ST_PL_RD;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = rstat_q;
          slot_d      = rslot_q;
          hkey_d      = rhkey_q;
          htag_d      = rhtag_q;
          occ_d       = cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    tag_q    <= tag_d;
    prev_q   <= prev_d;
    lo_q     <= lo_d;
    seen_q   <= seen_d;
    rstat_q  <= rstat_d;
    rslot_q  <= rslot_d;
    rhkey_q  <= rhkey_d;
    rhtag_q  <= rhtag_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    occ_q    <= occ_d;
    hkey_q   <= hkey_d;
    htag_q   <= htag_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign head_key_o  = hkey_q;
  assign head_tag_o  = htag_q;
  assign occupancy_o = occ_q;

`include "one_way_elevator_request_sort_top_assert.svh"

  `OWERS_ASSERT(a_cnt_bound, cnt_q <= CntFull, "entry count beyond depth")
  `OWERS_ASSERT(a_ins_room, (state_q != ST_INS_WR) || (cnt_q < CntFull), "insert into full queue")
  `OWERS_ASSERT(a_full_occ, !out_valid_q || (status_q != StatusFull) || (occ_q == CntFull), "full status with room left")
  `OWERS_ASSERT_NEXT(a_take_busy, in_valid_i && in_ready_o, state_q != ST_IDLE, "sequencer idle after transfer")

endmodule

// ===== tb/sv/one_way_elevator_request_sort_top_test.sv =====
`timescale 1ns / 100ps

// Scoreboard: keeps a copy of the request queue and the expected results.
class owers_scoreboard;
  localparam int Depth = 16;

  logic [31:0] queue_keys[Depth];
  logic [7:0]  queue_tags[Depth];
  int unsigned queue_count;
  int unsigned error_count;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [31:0] head_key;
    logic [7:0]  head_tag;
    logic [4:0]  occupancy;
  } result_t;

  result_t pending_results[$];

  function new();
    queue_count = 0;
    error_count = 0;
  endfunction

  // Index of the entry after which a new key lands; queue not empty.
  function int unsigned insert_after(logic [31:0] key);
    int unsigned i;
    i = 0;
    if (key < queue_keys[0]) begin
      // skip to the first inversion, then into the second run
      while (i + 1 < queue_count && queue_keys[i+1] >= queue_keys[i]) i++;
      while (i + 1 < queue_count && key >= queue_keys[i+1]) i++;
    end else begin
      while (i + 1 < queue_count && queue_keys[i+1] >= queue_keys[i] &&
             key >= queue_keys[i+1]) i++;
    end
    return i;
  endfunction

  // Note an accepted input transfer and predict its result.
  function void note_request(logic mode, logic [31:0] key, logic [7:0] tag);
    result_t r;
    int unsigned pos;
    r = '0;
    if (mode == owers_pkg::ModeInsert) begin
      if (queue_count >= Depth) begin
        r.status = owers_pkg::StatusFull;
      end else begin
        pos = (queue_count == 0) ? 0 : insert_after(key) + 1;
        for (int unsigned i = queue_count; i > pos; i--) begin
          queue_keys[i] = queue_keys[i-1];
          queue_tags[i] = queue_tags[i-1];
        end
        queue_keys[pos] = key;
        queue_tags[pos] = tag;
        queue_count++;
        r.status = owers_pkg::StatusOk;
        r.slot   = pos[4:0];
      end
    end else begin
      if (queue_count == 0) begin
        r.status = owers_pkg::StatusEmpty;
      end else begin
        r.status   = owers_pkg::StatusOk;
        r.head_key = queue_keys[0];
        r.head_tag = queue_tags[0];
        for (int unsigned i = 0; i + 1 < queue_count; i++) begin
          queue_keys[i] = queue_keys[i+1];
          queue_tags[i] = queue_tags[i+1];
        end
        queue_count--;
      end
    end
    r.occupancy = queue_count[4:0];
    pending_results.push_back(r);
  endfunction

  // Check one result transfer against the oldest expectation.
  function void check_result(result_t got);
    result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected result transfer");
      error_count++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      error_count++;
    end
    if (got.slot !== exp_r.slot) begin
      $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
      error_count++;
    end
    if (got.head_key !== exp_r.head_key) begin
      $error("head_key: expected %h, got %h", exp_r.head_key, got.head_key);
      error_count++;
    end
    if (got.head_tag !== exp_r.head_tag) begin
      $error("head_tag: expected %h, got %h", exp_r.head_tag, got.head_tag);
      error_count++;
    end
    if (got.occupancy !== exp_r.occupancy) begin
      $error("occupancy: expected %0d, got %0d", exp_r.occupancy, got.occupancy);
      error_count++;
    end
  endfunction
endclass

module one_way_elevator_request_sort_top_test;
  import owers_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = ModeInsert;
  logic [31:0] req_key_i = '0;
  logic [7:0]  req_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [4:0]  slot_o;
  logic [31:0] head_key_o;
  logic [7:0]  head_tag_o;
  logic [4:0]  occupancy_o;

  owers_scoreboard queue_model = new();
  int unsigned cycle_count = 0;
  bit          quiet_gaps = 1'b0;

  one_way_elevator_request_sort_top uut (.*);

  always #6 clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[one_way_elevator_request_sort_top] ERROR");
      $finish;
    end
  end

  // Note input transfers and check result transfers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      queue_model.note_request(mode_i, req_key_i, req_tag_i);
    if (rst_ni && out_valid_o && out_ready_i)
      queue_model.check_result({status_o, slot_o, head_key_o, head_tag_o, occupancy_o});
  end

  // Receiver: random stalls between result transfers
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = quiet_gaps ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Present one request and hold it until transferred
  task automatic send_request(logic mode, logic [31:0] key, logic [7:0] tag);
    int unsigned gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    req_key_i  <= key;
    req_tag_i  <= tag;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] random_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned pops;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, extremes, equal keys, wrap into second run, full
    send_request(ModePop, '0, '0);
    send_request(ModeInsert, 32'd100, 8'h00);
    send_request(ModeInsert, 32'd100, 8'hFF);
    send_request(ModeInsert, 32'hFFFF_FFFF, 8'h55);
    send_request(ModeInsert, 32'd0, 8'hAA);
    send_request(ModeInsert, 32'd50, 8'h01);
    send_request(ModeInsert, 32'd0, 8'h02);
    send_request(ModeInsert, 32'd200, 8'h03);
    for (int i = 0; i < 10; i++) send_request(ModeInsert, $urandom(), 8'($urandom()));
    for (int i = 0; i < 18; i++) send_request(ModePop, $urandom(), 8'($urandom()));

    // Random: bursts of inserts and pops so the queue swings between empty and full
    for (int n = 0; n < 1200; n++) begin
      if (n % 100 == 0) quiet_gaps = ($urandom_range(0, 3) == 0);
      if (n % 40 < 22)
        send_request($urandom_range(0, 4) == 0 ? ModePop : ModeInsert,
                     random_key(), 8'($urandom()));
      else
        send_request($urandom_range(0, 4) == 0 ? ModeInsert : ModePop,
                     random_key(), 8'($urandom()));
    end
    in_valid_i <= 1'b0;

    while (queue_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (queue_model.error_count == 0 && !out_valid_o)
      $display("[one_way_elevator_request_sort_top] OK");
    else
      $display("[one_way_elevator_request_sort_top] ERROR");
    $finish;
  end
endmodule
